/* hdl/urba_pkg.sv */
// ============================================================================
// urba_pkg
// Shared types and constants of the uniform ring bump allocator.
// ============================================================================
package urba_pkg;

    localparam int SLOT_COUNT    = 3;
    localparam int SLOT_CAPACITY = 128 * 1024;
    localparam int CACHE_ENTRIES = 8;

    localparam int SLOT_W  = 2;
    localparam int OFS_W   = 18;
    localparam int BYTE_W  = 24;
    localparam int BIND_W  = 8;
    localparam int BUF_W   = 32;
    localparam int RANGE_W = 31;
    localparam int MASK_W  = 8;
    localparam int CFG_W   = 8;
    localparam int CFG_IDX_W = 1;

    localparam int FILL_W = $clog2(SLOT_CAPACITY + 1);
    localparam int AL_W   = FILL_W + 1;
    localparam int SUM_W  = BYTE_W + 1;
    localparam int CIDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

    typedef enum logic [1:0] {
        OP_ACQUIRE    = 2'd0,
        OP_UPLOAD     = 2'd1,
        OP_BIND       = 2'd2,
        OP_INVALIDATE = 2'd3
    } op_t;

    localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_MASK = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VALIDATE   = 1'd1;

    typedef struct packed {
        logic [BUF_W-1:0]   buffer_id;
        logic [RANGE_W-1:0] range_offset;
        logic [RANGE_W-1:0] range_size;
    } cache_entry_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clear;
    } cache_ctl_t;

endpackage

/* hdl/urba_bind_cache.sv */
// ============================================================================
// urba_bind_cache
// Bind range cache: synchronous memory with per-entry valid bits; an entry
// that is not valid reads as all zeros.
// ============================================================================
module urba_bind_cache
    import urba_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cache_ctl_t        ctl,
    input  logic [CIDX_W-1:0] rd_idx,
    input  logic [CIDX_W-1:0] wr_idx,
    input  cache_entry_t      wr_entry,
    output cache_entry_t      rd_entry
);

    cache_entry_t                 mem [CACHE_ENTRIES];
    cache_entry_t                 rd_data_reg;
    logic                         rd_valid_reg;
    logic [CACHE_ENTRIES-1:0]     valid_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[wr_idx] <= wr_entry;
        end
        if (ctl.rd_en) begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (ctl.clear) begin
                valid_reg <= '0;
            end else if (ctl.wr_en) begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (ctl.rd_en) begin
                rd_valid_reg <= valid_reg[rd_idx];
            end
        end
    end

    assign rd_entry = rd_valid_reg ? rd_data_reg : '0;

endmodule

/* hdl/uniform_ring_bump_allocator.sv */
// ============================================================================
// uniform_ring_bump_allocator
// Ring of uniform slots with a bump allocator and a range bind cache.
// ============================================================================
// Usage:
//   s_* carries one command word (acquire, upload, bind range, invalidate);
//   m_* returns exactly one result word per command. Both use valid/ready.
//   cfg_* writes align_mask (index 0) or validate_enable (index 1); it is
//   always ready and must only be used while no command is in flight.
// Sequence:
//   The accept cycle reads the bind cache entry from its synchronous memory;
//   the execute state (ST_EXEC) then compares, writes back and loads the
//   result register. No new command is accepted until the current one has
//   loaded its result register.
// Stall:
//   A waiting result does not block the next accept; the following command
//   then holds in its execute cycle until the result register frees up.
// Reset:
//   Slot 0, empty fill offset, all cache entries zero (valid bits cleared),
//   align_mask 15, validate_enable 0. No clearing pass is needed.
// ============================================================================
module uniform_ring_bump_allocator
    import urba_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_opcode,
    input  logic [BYTE_W-1:0]    s_byte_count,
    input  logic [BIND_W-1:0]    s_bind_index,
    input  logic [BUF_W-1:0]     s_buffer_id,
    input  logic [RANGE_W-1:0]   s_range_offset,
    input  logic [RANGE_W-1:0]   s_range_size,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [SLOT_W-1:0]    m_slot_index,
    output logic [OFS_W-1:0]     m_upload_offset,
    output logic                 m_overflowed,
    output logic                 m_bind_skipped,
    output logic                 m_bind_issued,
    output logic                 m_misaligned,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t              state_reg;
    logic                m_valid_reg;
    logic [SLOT_W-1:0]   slot_reg,   slot_next;
    logic [FILL_W-1:0]   fill_reg,   fill_next;
    logic [MASK_W-1:0]   align_mask_reg;
    logic                validate_reg;

    op_t                 op_reg;
    logic [BYTE_W-1:0]   bytes_reg;
    logic [BIND_W-1:0]   bind_idx_reg;
    cache_entry_t        req_reg;

    logic [OFS_W-1:0]    m_upload_offset_reg;
    logic                m_overflowed_reg;
    logic                m_bind_skipped_reg;
    logic                m_bind_issued_reg;
    logic                m_misaligned_reg;

    logic                in_accept;
    logic                out_free;
    logic                exec_done;
    logic                cached;
    logic                hit;
    logic [AL_W-1:0]     mask_ext;
    logic [AL_W-1:0]     aligned;
    logic [SUM_W-1:0]    end_sum;
    logic                ovf;
    logic                mis;
    cache_ctl_t          cache_ctl;
    cache_entry_t        rd_entry;

    assign in_accept = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;
    assign exec_done = (state_reg == ST_EXEC) && out_free;

    assign cached   = (bind_idx_reg < BIND_W'(CACHE_ENTRIES));
    assign hit      = cached && (rd_entry == req_reg);
    assign mask_ext = AL_W'(align_mask_reg);
    assign aligned  = (AL_W'(fill_reg) + mask_ext) & ~mask_ext;
    assign end_sum  = SUM_W'(aligned) + SUM_W'(bytes_reg);
    assign ovf      = (end_sum > SUM_W'(SLOT_CAPACITY));
    assign mis      = validate_reg
                      && ((req_reg.range_offset[MASK_W-1:0] & align_mask_reg) != '0);

    always_comb begin
        cache_ctl.rd_en = in_accept;
        cache_ctl.wr_en = exec_done && (op_reg == OP_BIND) && cached && !hit;
        cache_ctl.clear = exec_done
                          && ((op_reg == OP_ACQUIRE) || (op_reg == OP_INVALIDATE));
    end

    always_comb begin
        slot_next = slot_reg;
        fill_next = fill_reg;
        case (op_reg)
            OP_ACQUIRE: begin
                slot_next = (slot_reg == SLOT_W'(SLOT_COUNT - 1)) ? '0 : slot_reg + 1'b1;
                fill_next = '0;
            end
            OP_UPLOAD: begin
                if (!ovf) begin
                    fill_next = FILL_W'(end_sum);
                end
            end
            OP_INVALIDATE: begin
                slot_next = '0;
                fill_next = '0;
            end
            default: begin
            end
        endcase
    end

    urba_bind_cache u_cache (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (cache_ctl),
        .rd_idx   (s_bind_index[CIDX_W-1:0]),
        .wr_idx   (bind_idx_reg[CIDX_W-1:0]),
        .wr_entry (req_reg),
        .rd_entry (rd_entry)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            slot_reg       <= '0;
            fill_reg       <= '0;
            align_mask_reg <= MASK_W'(15);
            validate_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_ALIGN_MASK: align_mask_reg <= cfg_data[MASK_W-1:0];
                    CFG_VALIDATE:   validate_reg   <= cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (m_valid_reg && m_ready && !exec_done) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_accept) begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (out_free) begin
                        state_reg           <= ST_IDLE;
                        m_valid_reg         <= 1'b1;
                        slot_reg            <= slot_next;
                        fill_reg            <= fill_next;
                        m_upload_offset_reg <= ((op_reg == OP_UPLOAD) && !ovf)
                                               ? OFS_W'(aligned) : '0;
                        m_overflowed_reg    <= (op_reg == OP_UPLOAD) && ovf;
                        m_bind_skipped_reg  <= (op_reg == OP_BIND) && hit;
                        m_bind_issued_reg   <= (op_reg == OP_BIND) && !hit;
                        m_misaligned_reg    <= (op_reg == OP_BIND) && !hit && mis;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            op_reg               <= op_t'(s_opcode);
            bytes_reg            <= s_byte_count;
            bind_idx_reg         <= s_bind_index;
            req_reg.buffer_id    <= s_buffer_id;
            req_reg.range_offset <= s_range_offset;
            req_reg.range_size   <= s_range_size;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_slot_index    = slot_reg;
    assign m_upload_offset = m_upload_offset_reg;
    assign m_overflowed    = m_overflowed_reg;
    assign m_bind_skipped  = m_bind_skipped_reg;
    assign m_bind_issued   = m_bind_issued_reg;
    assign m_misaligned    = m_misaligned_reg;

endmodule

/* hdl/urba_checker.sv */
// ============================================================================
// urba_checker
// Port-level checks of the uniform ring bump allocator, bound to the top.
// ============================================================================
module urba_checker
    import urba_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [SLOT_W-1:0]    m_slot_index,
    input logic [OFS_W-1:0]     m_upload_offset,
    input logic                 m_overflowed,
    input logic                 m_bind_skipped,
    input logic                 m_bind_issued,
    input logic                 m_misaligned
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result word dropped before accept");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second command accepted while one is in flight");

    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_slot_index < SLOT_W'(SLOT_COUNT)))
        else $error("slot index out of ring");

    a_ovf_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_overflowed |-> (m_upload_offset == '0) && !m_bind_issued)
        else $error("overflow with nonzero offset or bind");

    a_bind_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_bind_skipped && m_bind_issued) && !(m_misaligned && !m_bind_issued))
        else $error("inconsistent bind flags");

endmodule

bind uniform_ring_bump_allocator urba_checker u_urba_checker (.*);
